FILE: design/isr_pkg.sv
// Shared widths and the per-cell data record for the square root pipeline.
`default_nettype none

package isr_pkg;

    localparam int RADICAND_W = 32;
    localparam int STEPS      = RADICAND_W / 2;
    localparam int PART_W     = STEPS;
    localparam int REM_W      = STEPS + 1;
    localparam int ROOT_W     = STEPS + 1;

    typedef struct packed {
        logic                  cmd;
        logic [REM_W-1:0]      rem;
        logic [PART_W-1:0]     part;
        logic [RADICAND_W-1:0] bits;
    } t_cell_data;

endpackage

`default_nettype wire

FILE: design/isr_cell.sv
// One digit-by-digit step: bring down two radicand bits and try the next root bit.
`default_nettype none

module isr_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  isr_pkg::t_cell_data i_data,
    output logic                o_valid,
    output isr_pkg::t_cell_data o_data
);
    import isr_pkg::*;

    logic                  r_valid;
    t_cell_data            r_data;
    t_cell_data            n_data;
    logic [REM_W+1:0]      w_work;
    logic [REM_W+1:0]      w_trial;
    logic [REM_W+1:0]      w_diff;
    logic                  w_fit;

    // Remainder with the next two radicand bits appended, against 4*root + 1.
    assign w_work  = {i_data.rem, i_data.bits[RADICAND_W-1 -: 2]};
    assign w_trial = {1'b0, i_data.part, 2'b01};
    assign w_fit   = (w_work >= w_trial);
    assign w_diff  = w_work - w_trial;

    always_comb begin
        n_data.cmd  = i_data.cmd;
        n_data.rem  = w_fit ? w_diff[REM_W-1:0] : w_work[REM_W-1:0];
        n_data.part = {i_data.part[PART_W-2:0], w_fit};
        n_data.bits = {i_data.bits[RADICAND_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Remainder never exceeds twice the partial root.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ({1'b0, r_data.rem} <= {1'b0, r_data.part, 1'b0}))
        else $error("isr_cell: remainder above twice the partial root");

endmodule

`default_nettype wire

FILE: design/isr_round.sv
// Output stage: optional round-to-nearest and the registered result strobe.
`default_nettype none

module isr_round (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    input  isr_pkg::t_cell_data         i_data,
    output logic                        o_done,
    output logic [isr_pkg::ROOT_W-1:0]  o_root
);
    import isr_pkg::*;

    logic              r_done;
    logic [ROOT_W-1:0] r_root;
    logic [ROOT_W-1:0] n_root;
    logic [ROOT_W-1:0] w_floor;
    logic              w_up;

    assign w_floor = {1'b0, i_data.part};
    // Round up when the remainder exceeds the floor root; no ties exist.
    assign w_up    = i_data.cmd && (i_data.rem > w_floor);
    assign n_root  = w_floor + ROOT_W'(w_up);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

FILE: design/integer_square_root.sv
// Top level: 32-bit unsigned square root as a row of 16 step cells and a rounding stage.
// A request passes the 16 cell registers and then the round register before o_done.
// Throughput: one request per cycle; each cell row does one root bit, so o_busy stays low.
// Results show for exactly one cycle on o_root with o_done; the receiver cannot stall.
// Reset (i_rst_n low, synchronous) clears only the valid bits of every row.
`default_nettype none

module integer_square_root (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_start,
    output logic                        o_busy,
    input  wire [isr_pkg::RADICAND_W-1:0] i_radicand,
    input  wire                         i_command,
    output logic                        o_done,
    output logic [isr_pkg::ROOT_W-1:0]  o_root
);
    import isr_pkg::*;

    // Chain taps: index 0 is the incoming request, index STEPS the last cell.
    logic       w_valid [STEPS+1];
    t_cell_data w_data  [STEPS+1];
    logic       w_accept;

    // Every row advances every cycle, so a new request is always welcome.
    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;

    // Seed the chain: empty remainder and root, radicand bits queued at the top.
    assign w_valid[0]     = w_accept;
    assign w_data[0].cmd  = i_command;
    assign w_data[0].rem  = '0;
    assign w_data[0].part = '0;
    assign w_data[0].bits = i_radicand;

    // One cell per root bit, most significant first.
    for (genvar g = 0; g < STEPS; g++) begin : g_cell
        isr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    // Apply rounding mode and hold the result for its single strobe cycle.
    isr_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[STEPS]),
        .i_data  (w_data[STEPS]),
        .o_done  (o_done),
        .o_root  (o_root)
    );

    // Each strobe traces back to a request accepted at the head of the cell chain.
    a_done_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_accept, STEPS + 1))
        else $error("integer_square_root: result without matching request");

    // A rounded root never goes past 2^16.
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!o_root[ROOT_W-1] || (o_root[ROOT_W-2:0] == '0)))
        else $error("integer_square_root: root out of range");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the pipelined 32-bit integer square root.
`default_nettype none

module tb;
    import isr_pkg::*;

    localparam logic CMD_FLOOR = 1'b0;
    localparam logic CMD_ROUND = 1'b1;

    localparam int LATENCY    = 17;
    localparam int DRAIN_WAIT = 3 * LATENCY;
    localparam int IDLE_LIMIT = 1000;

    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  i_start    = 1'b0;
    logic [RADICAND_W-1:0] i_radicand = '0;
    logic                  i_command  = CMD_FLOOR;
    logic                  o_busy;
    logic                  o_done;
    logic [ROOT_W-1:0]     o_root;

    logic [ROOT_W-1:0] pending_roots[$];
    int                error_count = 0;
    int                floor_count = 0;
    int                round_count = 0;
    int                root_checks = 0;
    int                idle_cycles = 0;
    bit                bursting    = 1'b0;

    integer_square_root dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_radicand (i_radicand),
        .i_command  (i_command),
        .o_done     (o_done),
        .o_root     (o_root)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Restoring digit-by-digit root: try each bit of the root from the top,
    // keep it when 2*g*b + b*b still fits in what is left of the radicand.
    function automatic logic [ROOT_W-1:0] predict_root(input logic [RADICAND_W-1:0] radicand,
                                                       input logic command);
        logic [RADICAND_W+1:0] left_over;
        logic [RADICAND_W+1:0] trial;
        logic [ROOT_W-1:0]     guess;
        int                    k;
        left_over = {2'b00, radicand};
        guess     = '0;
        for (k = STEPS - 1; k >= 0; k--) begin
            trial = ({{(RADICAND_W+2-ROOT_W){1'b0}}, guess} << (k + 1))
                    + ({{(RADICAND_W+1){1'b0}}, 1'b1} << (2 * k));
            if (left_over >= trial) begin
                left_over = left_over - trial;
                guess     = guess | (ROOT_W'(1) << k);
            end
        end
        // Round up exactly when the remainder passes the floor root; no tie exists.
        if (command == CMD_ROUND && left_over > {{(RADICAND_W+2-ROOT_W){1'b0}}, guess})
            guess = guess + 1'b1;
        return guess;
    endfunction

    // Mostly short gaps, some long ones, none at all while bursting.
    function automatic int pick_gap();
        int r;
        if (bursting)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Present one request and hold it until the block takes it. Acceptance is
    // decided from values sampled on the falling edge, so there is no race
    // with the block's own updates at the rising edge.
    task automatic send_request(input logic [RADICAND_W-1:0] radicand, input logic command);
        bit taken;
        i_start    <= 1'b1;
        i_radicand <= radicand;
        i_command  <= command;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_busy;
            @(posedge i_clk);
        end
        pending_roots.push_back(predict_root(radicand, command));
        if (command == CMD_ROUND)
            round_count++;
        else
            floor_count++;
    endtask

    // Drop start for a random number of cycles and scribble on the data lines,
    // which the block must ignore while no request is offered.
    task automatic idle_between();
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_start    <= 1'b0;
            i_radicand <= $urandom;
            i_command  <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_and_idle(input logic [RADICAND_W-1:0] radicand, input logic command);
        send_request(radicand, command);
        idle_between();
    endtask

    // Field extremes, both commands, perfect squares and the top of the range.
    task automatic test_extremes();
        send_and_idle(32'd0, CMD_FLOOR);
        send_and_idle(32'd0, CMD_ROUND);
        send_and_idle(32'd1, CMD_FLOOR);
        send_and_idle(32'd1, CMD_ROUND);
        send_and_idle(32'd15, CMD_FLOOR);
        send_and_idle(32'd16, CMD_ROUND);
        send_and_idle(32'd65536, CMD_FLOOR);
        send_and_idle(32'h8000_0000, CMD_FLOOR);
        send_and_idle(32'h8000_0000, CMD_ROUND);
        send_and_idle(32'h5555_5555, CMD_ROUND);
        send_and_idle(32'hAAAA_AAAA, CMD_FLOOR);
        send_and_idle(32'd4294836225, CMD_FLOOR);  // 65535 squared
        send_and_idle(32'hFFFF_FFFF, CMD_FLOOR);
        send_and_idle(32'hFFFF_FFFF, CMD_ROUND);   // rounds past 16 bits
    endtask

    // Rounding edges: the remainder equal to the floor root stays down, one
    // more goes up; two of the same radicands in floor mode stay down.
    task automatic test_rounding_edge();
        send_and_idle(32'd2, CMD_ROUND);
        send_and_idle(32'd3, CMD_ROUND);
        send_and_idle(32'd6, CMD_ROUND);
        send_and_idle(32'd7, CMD_ROUND);
        send_and_idle(32'd7, CMD_FLOOR);
        send_and_idle(32'd4294901760, CMD_ROUND);
        send_and_idle(32'd4294901761, CMD_ROUND);
        send_and_idle(32'd4294901761, CMD_FLOOR);
    endtask

    // Random radicands with a bias toward squares, rounding boundaries and the top of the range,
    // alternating stretches of random gaps with back-to-back bursts.
    task automatic test_random(input int count);
        logic [RADICAND_W-1:0] radicand;
        logic [PART_W-1:0]     base;
        int                    pick;
        int                    n;
        for (n = 0; n < count; n++) begin
            if (n % 50 == 0)
                bursting = (n / 50) % 2 == 1;
            base = PART_W'($urandom_range(0, 65535));
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2, 3: begin
                    radicand = $urandom;
                end
                4: begin
                    radicand = $urandom_range(0, 300);
                end
                5, 6: begin
                    // Around a perfect square; wraps at zero on purpose.
                    radicand = base * base + RADICAND_W'($urandom_range(0, 4)) - 2;
                end
                7, 8: begin
                    // Around g*g + g, where rounding flips.
                    radicand = base * base + base + RADICAND_W'($urandom_range(0, 2)) - 1;
                end
                default: begin
                    radicand = 32'hFFFF_FFFF - RADICAND_W'($urandom_range(0, 200000));
                end
            endcase
            send_and_idle(radicand, 1'($urandom_range(0, 1)));
        end
        bursting = 1'b0;
    endtask

    // Compare each result strobe with the oldest expectation. Sample on the
    // falling edge, halfway between the block's updates.
    always @(negedge i_clk) begin : check_roots
        logic [ROOT_W-1:0] want;
        if (i_rst_n && o_done) begin
            if (pending_roots.size() == 0) begin
                $error("unexpected result: root %0d with no request outstanding", o_root);
                error_count++;
            end else begin
                want = pending_roots.pop_front();
                root_checks++;
                if (o_root !== want) begin
                    $error("root mismatch: expected %0d, actual %0d", want, o_root);
                    error_count++;
                end
            end
        end
    end

    // Stop the run when neither a request nor a result moves for too long.
    always @(negedge i_clk) begin
        if ((i_start && !o_busy) || o_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no request or result for %0d cycles", IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_rounding_edge();
        test_random(400);

        // Release start after the last request and drain the pipeline.
        i_start <= 1'b0;
        while (pending_roots.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d floor and %0d rounding requests; checked %0d roots,",
                 floor_count, round_count, root_checks);
        $display("covering range ends, squares, rounding edges, gaps and bursts.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
